[rtl/epoch_seconds_to_calendar_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the seconds-to-calendar block
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication
`define ECAL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ecal assertion failed");

// Implication after a fixed number of cycles
`define ECAL_ASSERT_LAT(lbl, ante, n, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("ecal latency assertion failed");

`endif

[rtl/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// ecal_pkg
// Types, constants and calendar tables for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ecal_pkg;

   // Reset value of the base register: local 2000-01-01 00:00:00
   localparam logic [30:0] BASE_RESET = 31'd946656000;

   // Seconds per day = 2^7 * 675; divide by 675 with a reciprocal
   localparam int          DAY_LO_BITS     = 7;
   localparam logic [9:0]  DAY_DIV         = 10'd675;
   localparam logic [24:0] DAY_RECIP       = 25'd25451658;   // floor(2^34 / 675)

   // Four-year cycle, valid through 2099 (2000 is a leap year, 2100 is not)
   localparam logic [10:0] QUAD_DAYS       = 11'd1461;
   localparam logic [15:0] QUAD_RECIP      = 16'd45933;      // floor(2^26 / 1461)
   localparam logic [10:0] YEAR1_START     = 11'd366;
   localparam logic [10:0] YEAR2_START     = 11'd731;
   localparam logic [10:0] YEAR3_START     = 11'd1096;
   localparam logic [11:0] YEAR_BASE       = 12'd2000;

   // Time of day
   localparam logic [11:0] HOUR_SECS       = 12'd3600;
   localparam logic [18:0] HOUR_RECIP      = 19'd298261;     // floor(2^30 / 3600)
   localparam logic [5:0]  MIN_SECS        = 6'd60;
   localparam logic [10:0] MIN_RECIP       = 11'd1092;       // floor(2^16 / 60)

   // Control bits that travel with each item
   typedef struct packed {
      logic valid;
      logic neg;
   } ecal_ctrl_type;

   // Calendar date of one item
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } ecal_date_type;

   // First day of year (zero based) of a month, February 29 counted when leap
   function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
      logic [8:0] base;
      case (mon)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (mon > 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

[rtl/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Signed seconds count to calendar date and time of day, base register set.
// Usage:
//   Input: an item transfers on a clock edge with start high and busy low.
//   busy is never raised, so a new item may be given in every cycle.
//   Output: each result is shown for one cycle with rsp_valid high and
//   cannot be held off by the receiver.
//   Results pass through the ten register stages of reciprocal multiplies
//   and corrections (days, quad years, hours, minutes); throughput is one
//   item per cycle, since every stage takes a new item in each cycle.
//   A count below the base gives rsp_before_base high and all fields zero.
//   Configuration: csr_write_enable writes csr_write_data to the base
//   register; write only while no item is in flight.
//   Reset clears the pipeline valid bits and restores the base register.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_seconds_count,
   input  logic        csr_write_enable,
   input  logic [30:0] csr_write_data,
   output logic        rsp_valid,
   output logic        rsp_before_base,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);
   import ecal_pkg::*;

   logic [30:0] base_ff;

   ecal_ctrl_type s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff, s4_ctrl_ff;
   ecal_ctrl_type date_ctrl;
   ecal_date_type date_out;

   logic [30:0] s1_rem_ff, s2_rem_ff;
   logic [14:0] s2_q_ff, s3_q_ff, s4_days_ff;
   logic [10:0] s3_r_ff;
   logic [6:0]  s3_lo_ff;
   logic [16:0] s4_sod_ff;

   logic        t5_neg_ff, t6_neg_ff, t7_neg_ff, t8_neg_ff, t9_neg_ff;
   logic [4:0]  t5_h_ff, t6_h_ff, t7_h_ff, t8_h_ff, t9_h_ff, t10_h_ff;
   logic [16:0] t5_sod_ff;
   logic [12:0] t6_rh_ff;
   logic [11:0] t7_rs_ff, t8_rs_ff;
   logic [5:0]  t8_m_ff, t9_m_ff, t10_m_ff;
   logic [6:0]  t9_rm_ff;
   logic [5:0]  t10_s_ff;

   logic [32:0] diff;
   logic [48:0] day_prod;
   logic [24:0] day_back;
   logic [23:0] day_r_full;
   logic [14:0] s4_days_in;
   logic [9:0]  s4_r_in;
   logic [35:0] hour_prod;
   logic [16:0] hour_back;
   logic [16:0] rh_full;
   logic [4:0]  t7_h_in;
   logic [11:0] t7_rs_in;
   logic [22:0] min_prod;
   logic [11:0] min_back;
   logic [11:0] rm_full;
   logic [4:0]  t10_h_in;
   logic [5:0]  t10_m_in;
   logic [5:0]  t10_s_in;
   logic        rsp_fields_zero;
   logic        rsp_fields_legal;

   // Never stalls
   assign busy = 1'b0;

   // Base register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   // Control pipe through the day split
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
         s4_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff.valid <= start && !busy;
         s1_ctrl_ff.neg   <= diff[32];
         s2_ctrl_ff       <= s1_ctrl_ff;
         s3_ctrl_ff       <= s2_ctrl_ff;
         s4_ctrl_ff       <= s3_ctrl_ff;
      end
   end

   // Stage 1: exact signed difference in 33 bits
   assign diff = {req_seconds_count[31], req_seconds_count} - {2'b00, base_ff};

   // Stage 2: day estimate, seconds / 86400 = (seconds >> 7) / 675
   assign day_prod = 49'(s1_rem_ff[30:DAY_LO_BITS]) * 49'(DAY_RECIP);

   // Stage 3: remainder against the estimate
   assign day_back   = 25'(s2_q_ff) * 25'(DAY_DIV);
   assign day_r_full = s2_rem_ff[30:DAY_LO_BITS] - day_back[23:0];

   // Stage 4: correct the estimate
   always_comb begin
      if (s3_r_ff >= 11'(DAY_DIV)) begin
         s4_days_in = s3_q_ff + 15'd1;
         s4_r_in    = 10'(s3_r_ff - 11'(DAY_DIV));
      end else begin
         s4_days_in = s3_q_ff;
         s4_r_in    = s3_r_ff[9:0];
      end
   end

   always_ff @(posedge clock) begin
      s1_rem_ff  <= diff[30:0];
      s2_rem_ff  <= s1_rem_ff;
      s2_q_ff    <= day_prod[48:34];
      s3_q_ff    <= s2_q_ff;
      s3_r_ff    <= day_r_full[10:0];
      s3_lo_ff   <= s2_rem_ff[DAY_LO_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      s4_days_ff <= s4_days_in;
      s4_sod_ff  <= {s4_r_in, s3_lo_ff};
   end

   // Date lane
   ecal_date u_date (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (s4_ctrl_ff),
      .in_days  (s4_days_ff),
      .out_ctrl (date_ctrl),
      .out_date (date_out)
   );

   // Time lane: hour estimate, remainder, correction
   assign hour_prod = 36'(s4_sod_ff) * 36'(HOUR_RECIP);
   assign hour_back = 17'(t5_h_ff) * 17'(HOUR_SECS);
   assign rh_full   = t5_sod_ff - hour_back;

   always_comb begin
      if (t6_rh_ff >= 13'(HOUR_SECS)) begin
         t7_h_in  = t6_h_ff + 5'd1;
         t7_rs_in = 12'(t6_rh_ff - 13'(HOUR_SECS));
      end else begin
         t7_h_in  = t6_h_ff;
         t7_rs_in = t6_rh_ff[11:0];
      end
   end

   // Minute estimate, remainder, correction; zero before the base
   assign min_prod = 23'(t7_rs_ff) * 23'(MIN_RECIP);
   assign min_back = 12'(t8_m_ff) * 12'(MIN_SECS);
   assign rm_full  = t8_rs_ff - min_back;

   always_comb begin
      if (t9_neg_ff) begin
         t10_h_in = '0;
         t10_m_in = '0;
         t10_s_in = '0;
      end else if (t9_rm_ff >= 7'(MIN_SECS)) begin
         t10_h_in = t9_h_ff;
         t10_m_in = t9_m_ff + 6'd1;
         t10_s_in = 6'(t9_rm_ff - 7'(MIN_SECS));
      end else begin
         t10_h_in = t9_h_ff;
         t10_m_in = t9_m_ff;
         t10_s_in = t9_rm_ff[5:0];
      end
   end

   always_ff @(posedge clock) begin
      t5_neg_ff <= s4_ctrl_ff.neg;
      t6_neg_ff <= t5_neg_ff;
      t7_neg_ff <= t6_neg_ff;
      t8_neg_ff <= t7_neg_ff;
      t9_neg_ff <= t8_neg_ff;
      t5_h_ff   <= hour_prod[34:30];
      t5_sod_ff <= s4_sod_ff;
      t6_h_ff   <= t5_h_ff;
      t6_rh_ff  <= rh_full[12:0];
      t7_h_ff   <= t7_h_in;
      t7_rs_ff  <= t7_rs_in;
      t8_h_ff   <= t7_h_ff;
      t8_rs_ff  <= t7_rs_ff;
      t8_m_ff   <= min_prod[21:16];
      t9_h_ff   <= t8_h_ff;
      t9_m_ff   <= t8_m_ff;
      t9_rm_ff  <= rm_full[6:0];
      t10_h_ff  <= t10_h_in;
      t10_m_ff  <= t10_m_in;
      t10_s_ff  <= t10_s_in;
   end

   // Result transfer
   assign rsp_valid        = date_ctrl.valid;
   assign rsp_before_base  = date_ctrl.neg;
   assign rsp_year         = date_out.year;
   assign rsp_month        = date_out.month;
   assign rsp_day_of_month = date_out.day;
   assign rsp_hour         = t10_h_ff;
   assign rsp_minute       = t10_m_ff;
   assign rsp_second       = t10_s_ff;

   // Field summaries for the checks
   assign rsp_fields_zero  = (rsp_year == 12'd0) && (rsp_month == 4'd0) &&
                             (rsp_day_of_month == 5'd0) && (rsp_hour == 5'd0) &&
                             (rsp_minute == 6'd0) && (rsp_second == 6'd0);
   assign rsp_fields_legal = (rsp_month != 4'd0) && (rsp_month <= 4'd12) &&
                             (rsp_day_of_month != 5'd0) && (rsp_hour <= 5'd23) &&
                             (rsp_minute <= 6'd59) && (rsp_second <= 6'd59);

   // Checks
   `ECAL_ASSERT_LAT(a_latency, start && !busy, 10, rsp_valid)
   `ECAL_ASSERT_IMP(a_no_spurious, rsp_valid, $past(start && !busy, 10))
   `ECAL_ASSERT_IMP(a_before_base_zero, rsp_valid && rsp_before_base, rsp_fields_zero)
   `ECAL_ASSERT_IMP(a_field_range, rsp_valid && !rsp_before_base, rsp_fields_legal)

endmodule

[rtl/ecal_date.sv]
// ----------------------------------------------------------------------------
// ecal_date
// Day count since 2000-01-01 to year, month and day of month; six stages.
// ----------------------------------------------------------------------------
module ecal_date (
   input  logic                   clock,
   input  logic                   reset,
   input  ecal_pkg::ecal_ctrl_type in_ctrl,
   input  logic [14:0]            in_days,
   output ecal_pkg::ecal_ctrl_type out_ctrl,
   output ecal_pkg::ecal_date_type out_date
);
   import ecal_pkg::*;

   ecal_ctrl_type d5_ctrl_ff, d6_ctrl_ff, d7_ctrl_ff, d8_ctrl_ff, d9_ctrl_ff, d10_ctrl_ff;

   logic [4:0]  d5_q_ff,  d6_q_ff,  d7_q_ff,  d8_q_ff,  d9_q_ff;
   logic [14:0] d5_days_ff;
   logic [11:0] d6_rq_ff;
   logic [10:0] d7_rd_ff;
   logic [1:0]  d8_yoff_ff, d9_yoff_ff;
   logic [8:0]  d8_doy_ff,  d9_doy_ff;
   logic        d8_leap_ff, d9_leap_ff;
   logic [3:0]  d9_month_ff;
   ecal_date_type d10_date_ff;

   logic [30:0] quad_prod;
   logic [14:0] quad_back;
   logic [14:0] rq_full;
   logic [4:0]  d7_q_in;
   logic [10:0] d7_rd_in;
   logic [1:0]  d8_yoff_in;
   logic [8:0]  d8_doy_in;
   logic [3:0]  d9_month_in;
   logic [8:0]  day_idx;
   ecal_date_type d10_date_in;

   // Control pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         d5_ctrl_ff  <= '0;
         d6_ctrl_ff  <= '0;
         d7_ctrl_ff  <= '0;
         d8_ctrl_ff  <= '0;
         d9_ctrl_ff  <= '0;
         d10_ctrl_ff <= '0;
      end else begin
         d5_ctrl_ff  <= in_ctrl;
         d6_ctrl_ff  <= d5_ctrl_ff;
         d7_ctrl_ff  <= d6_ctrl_ff;
         d8_ctrl_ff  <= d7_ctrl_ff;
         d9_ctrl_ff  <= d8_ctrl_ff;
         d10_ctrl_ff <= d9_ctrl_ff;
      end
   end

   // Quad-year estimate: at most one low
   assign quad_prod = 31'(in_days) * 31'(QUAD_RECIP);

   // Remainder against the estimate
   assign quad_back = 15'(d5_q_ff) * 15'(QUAD_DAYS);
   assign rq_full   = d5_days_ff - quad_back;

   // Correct the estimate
   always_comb begin
      if (d6_rq_ff >= 12'(QUAD_DAYS)) begin
         d7_q_in  = d6_q_ff + 5'd1;
         d7_rd_in = 11'(d6_rq_ff - 12'(QUAD_DAYS));
      end else begin
         d7_q_in  = d6_q_ff;
         d7_rd_in = d6_rq_ff[10:0];
      end
   end

   // Year within the quad and day of year
   always_comb begin
      if (d7_rd_ff < YEAR1_START) begin
         d8_yoff_in = 2'd0;
         d8_doy_in  = d7_rd_ff[8:0];
      end else if (d7_rd_ff < YEAR2_START) begin
         d8_yoff_in = 2'd1;
         d8_doy_in  = 9'(d7_rd_ff - YEAR1_START);
      end else if (d7_rd_ff < YEAR3_START) begin
         d8_yoff_in = 2'd2;
         d8_doy_in  = 9'(d7_rd_ff - YEAR2_START);
      end else begin
         d8_yoff_in = 2'd3;
         d8_doy_in  = 9'(d7_rd_ff - YEAR3_START);
      end
   end

   // Month: last month whose first day is not past the day of year
   always_comb begin
      d9_month_in = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (d8_doy_ff >= month_start(4'(m), d8_leap_ff)) begin
            d9_month_in = 4'(m);
         end
      end
   end

   // Final fields, zero before the base
   assign day_idx = d9_doy_ff - month_start(d9_month_ff, d9_leap_ff) + 9'd1;

   always_comb begin
      if (d9_ctrl_ff.neg) begin
         d10_date_in = '0;
      end else begin
         d10_date_in.year  = YEAR_BASE + 12'({d9_q_ff, d9_yoff_ff});
         d10_date_in.month = d9_month_ff;
         d10_date_in.day   = day_idx[4:0];
      end
   end

   // Data pipe
   always_ff @(posedge clock) begin
      d5_q_ff     <= quad_prod[30:26];
      d5_days_ff  <= in_days;
      d6_q_ff     <= d5_q_ff;
      d6_rq_ff    <= rq_full[11:0];
      d7_q_ff     <= d7_q_in;
      d7_rd_ff    <= d7_rd_in;
      d8_q_ff     <= d7_q_ff;
      d8_yoff_ff  <= d8_yoff_in;
      d8_doy_ff   <= d8_doy_in;
      d8_leap_ff  <= (d8_yoff_in == 2'd0);
      d9_q_ff     <= d8_q_ff;
      d9_yoff_ff  <= d8_yoff_ff;
      d9_doy_ff   <= d8_doy_ff;
      d9_leap_ff  <= d8_leap_ff;
      d9_month_ff <= d9_month_in;
      d10_date_ff <= d10_date_in;
   end

   assign out_ctrl = d10_ctrl_ff;
   assign out_date = d10_date_ff;

endmodule
